@@ design/assert_macros.svh @@
// Assertion helpers used by the allocator design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/nfa_pkg.sv @@
package nfa_pkg;

   localparam int ID_COUNT   = 1024;
   localparam int WORD_SHIFT = 5;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) >> WORD_SHIFT;
   localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SLOT_W     = WORD_AW + WORD_SHIFT;
   localparam int CNT_W      = $clog2(WORD_COUNT + 1);
   localparam int ID_W       = 28;
   localparam int TYPE_W     = 4;
   localparam int HANDLE_W   = ID_W + TYPE_W;

   // Slots that exist in the last bitmap word.
   localparam int LAST_BITS = ID_COUNT - (WORD_COUNT - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_FREED     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_IGNORED   = 2'd3;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE
   } state_type;

   typedef struct packed {
      logic                  hit;
      logic [WORD_SHIFT-1:0] bit_pos;
   } pick_type;

endpackage

@@ design/next_fit_bitmap_id_allocator.sv @@
// Next-fit handle allocator over a used-bitmap of nfa_pkg::ID_COUNT slots, held
// 32 slots to a word in a one-port-read, one-port-write RAM. A request is taken
// when start is high and busy is low; its single response shows on rsp_handle
// and rsp_status for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it, so capture it in that cycle. A free of handle 0 or of a slot
// beyond range answers the cycle after it is taken and never raises busy. A
// valid free reads the word, then clears the bit and writes it back. An
// allocate first reads the word holding the slot one past the last grant; the
// scan then reads one word per cycle from the RAM until a free slot turns up,
// so the worst case (full or nearly full bitmap) reads WORD_COUNT + 1 words.
// The bitmap needs no clearing pass after reset: a per-word valid flag, cleared
// by reset, makes a never-written word read as all free.
module next_fit_bitmap_id_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [nfa_pkg::TYPE_W-1:0]    req_lane_type,
   input  logic [nfa_pkg::HANDLE_W-1:0]  req_request_handle,
   output logic                          rsp_valid,
   output logic [nfa_pkg::HANDLE_W-1:0]  rsp_handle,
   output logic [1:0]                    rsp_status
);

`include "assert_macros.svh"

   localparam logic [nfa_pkg::WORD_AW-1:0] LAST_WORD =
      nfa_pkg::WORD_AW'(nfa_pkg::WORD_COUNT - 1);

   nfa_pkg::state_type state_ff, state_in;

   logic [nfa_pkg::WORD_AW-1:0]    word_ff, word_in;
   logic [nfa_pkg::WORD_SHIFT-1:0] lo_bit_ff, lo_bit_in;
   logic [nfa_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [nfa_pkg::TYPE_W-1:0]     type_ff, type_in;
   logic [nfa_pkg::SLOT_W-1:0]     last_ff, last_in;
   logic [nfa_pkg::WORD_COUNT-1:0] valid_ff, valid_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nfa_pkg::HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;

   // RAM port signals
   logic                            rd_en, wr_en;
   logic [nfa_pkg::WORD_AW-1:0]     rd_addr;
   logic [nfa_pkg::WORD_BITS-1:0]   rd_data, wr_data;

   logic [nfa_pkg::WORD_BITS-1:0]   word_eff;
   logic [nfa_pkg::WORD_BITS-1:0]   lim_mask, ge_mask, search_mask;
   nfa_pkg::pick_type               pick;

   logic [nfa_pkg::SLOT_W-1:0]      next_slot, free_slot, grant_slot;
   logic [nfa_pkg::ID_W-1:0]        req_id;
   logic [nfa_pkg::WORD_AW-1:0]     next_word;

   nfa_ram #(
      .WIDTH (nfa_pkg::WORD_BITS),
      .DEPTH (nfa_pkg::WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nfa_pick u_pick (
      .used_word   (word_eff),
      .search_mask (search_mask),
      .pick        (pick)
   );

   // A word never written since reset holds no used slots.
   assign word_eff = valid_ff[word_ff] ? rd_data : '0;

   // Slots past ID_COUNT in the last word count as used. The first look at
   // the start word covers the start bit and above; the closing look covers
   // the bits below it, so the last granted slot is examined last.
   always_comb begin
      lim_mask = (word_ff == LAST_WORD) ? nfa_pkg::LAST_MASK : '1;
      ge_mask = '1 << lo_bit_ff;
      if (count_ff == '0) begin
         search_mask = lim_mask & ge_mask;
      end else if (count_ff == nfa_pkg::CNT_W'(nfa_pkg::WORD_COUNT)) begin
         search_mask = lim_mask & ~ge_mask;
      end else begin
         search_mask = lim_mask;
      end
   end

   assign next_slot = (last_ff == nfa_pkg::SLOT_W'(nfa_pkg::ID_COUNT - 1)) ?
                      '0 : last_ff + nfa_pkg::SLOT_W'(1);
   assign req_id     = req_request_handle[nfa_pkg::ID_W-1:0];
   assign free_slot  = nfa_pkg::SLOT_W'(req_id - nfa_pkg::ID_W'(1));
   assign grant_slot = {word_ff, pick.bit_pos};
   assign next_word  = (word_ff == LAST_WORD) ? '0 : word_ff + nfa_pkg::WORD_AW'(1);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      lo_bit_in     = lo_bit_ff;
      count_in      = count_ff;
      type_in       = type_ff;
      last_in       = last_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_data       = word_eff;

      case (state_ff)
         nfa_pkg::ST_IDLE: begin
            if (start) begin
               type_in = req_lane_type;
               if (req_action == nfa_pkg::ACTION_ALLOC) begin
                  // Fetch the word holding the slot one past the last grant.
                  word_in   = next_slot[nfa_pkg::SLOT_W-1:nfa_pkg::WORD_SHIFT];
                  lo_bit_in = next_slot[nfa_pkg::WORD_SHIFT-1:0];
                  count_in  = '0;
                  rd_en     = 1'b1;
                  rd_addr   = word_in;
                  state_in  = nfa_pkg::ST_SCAN;
               end else if (req_id == '0 ||
                            req_id > nfa_pkg::ID_W'(nfa_pkg::ID_COUNT)) begin
                  // Out-of-range free: answer at once, touch nothing.
                  rsp_valid_in  = 1'b1;
                  rsp_handle_in = '0;
                  rsp_status_in = nfa_pkg::STATUS_IGNORED;
               end else begin
                  word_in   = free_slot[nfa_pkg::SLOT_W-1:nfa_pkg::WORD_SHIFT];
                  lo_bit_in = free_slot[nfa_pkg::WORD_SHIFT-1:0];
                  rd_en     = 1'b1;
                  rd_addr   = word_in;
                  state_in  = nfa_pkg::ST_FREE;
               end
            end
         end
         nfa_pkg::ST_SCAN: begin
            if (pick.hit) begin
               // Mark the slot used and write the word back.
               wr_en             = 1'b1;
               wr_data           = word_eff | (nfa_pkg::WORD_BITS'(1) << pick.bit_pos);
               valid_in[word_ff] = 1'b1;
               last_in           = grant_slot;
               rsp_valid_in      = 1'b1;
               rsp_handle_in     = {type_ff,
                                    nfa_pkg::ID_W'(grant_slot) + nfa_pkg::ID_W'(1)};
               rsp_status_in     = nfa_pkg::STATUS_ALLOCATED;
               state_in          = nfa_pkg::ST_IDLE;
            end else if (count_ff == nfa_pkg::CNT_W'(nfa_pkg::WORD_COUNT)) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_status_in = nfa_pkg::STATUS_FULL;
               state_in      = nfa_pkg::ST_IDLE;
            end else begin
               // Advance to the next word, wrapping round.
               word_in  = next_word;
               count_in = count_ff + nfa_pkg::CNT_W'(1);
               rd_en    = 1'b1;
               rd_addr  = next_word;
            end
         end
         nfa_pkg::ST_FREE: begin
            wr_en             = 1'b1;
            wr_data           = word_eff & ~(nfa_pkg::WORD_BITS'(1) << lo_bit_ff);
            valid_in[word_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_handle_in     = '0;
            rsp_status_in     = nfa_pkg::STATUS_FREED;
            state_in          = nfa_pkg::ST_IDLE;
         end
         default: begin
            state_in = nfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfa_pkg::ST_IDLE;
         last_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      lo_bit_ff     <= lo_bit_in;
      count_ff      <= count_in;
      type_ff       <= type_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != nfa_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_status = rsp_status_ff;

   // An accepted request either starts work or answers in the next cycle.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "request dropped")
   // A granted handle never carries slot field zero.
   `ASSERT_IMPLIES(a_grant_nonzero, clock, reset, rsp_valid && rsp_status == nfa_pkg::STATUS_ALLOCATED, rsp_handle[nfa_pkg::ID_W-1:0] != '0, "zero grant")
   // Every other response carries handle zero.
   `ASSERT_IMPLIES(a_other_zero, clock, reset, rsp_valid && rsp_status != nfa_pkg::STATUS_ALLOCATED, rsp_handle == '0, "nonzero handle")
   // The scan never reads past the closing look at the start word.
   `ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == nfa_pkg::ST_SCAN, count_ff <= nfa_pkg::CNT_W'(nfa_pkg::WORD_COUNT), "scan overrun")

endmodule

@@ design/nfa_ram.sv @@
module nfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nfa_pick.sv @@
module nfa_pick (
   input  logic [nfa_pkg::WORD_BITS-1:0] used_word,
   input  logic [nfa_pkg::WORD_BITS-1:0] search_mask,
   output nfa_pkg::pick_type             pick
);

   logic [nfa_pkg::WORD_BITS-1:0] cand;

   // Lowest free slot among the searched positions wins.
   always_comb begin
      cand = ~used_word & search_mask;
      pick.hit = |cand;
      pick.bit_pos = '0;
      for (int i = nfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick.bit_pos = nfa_pkg::WORD_SHIFT'(i);
         end
      end
   end

endmodule

@@ tb/sv/next_fit_bitmap_id_allocator_tb.sv @@
module next_fit_bitmap_id_allocator_tb;
   import nfa_pkg::*;

   // One expected response: the handle and the status the allocator must answer.
   typedef struct {
      logic [HANDLE_W-1:0] handle;
      logic [1:0]          status;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_action;
   logic [TYPE_W-1:0]   req_lane_type;
   logic [HANDLE_W-1:0] req_request_handle;
   logic                rsp_valid;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [1:0]          rsp_status;

   // Shadow copy of the allocator: one used flag per slot plus the last grant.
   bit          slot_taken [ID_COUNT];
   int unsigned last_slot;

   // Responses still owed by the allocator, oldest first.
   reply_type   owed_replies[$];

   int mismatches;
   int requests_sent;
   int status_tally [4];
   int idle_pct;

   next_fit_bitmap_id_allocator DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_lane_type      (req_lane_type),
      .req_request_handle (req_request_handle),
      .rsp_valid          (rsp_valid),
      .rsp_handle         (rsp_handle),
      .rsp_status         (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the shadow state and return the response it earns.
   // Allocate searches next-fit: start one past the last grant, wrap, and look
   // at the last granted slot itself only at the very end.
   function automatic reply_type grant_or_release(input logic act,
                                                  input logic [TYPE_W-1:0] lane,
                                                  input logic [HANDLE_W-1:0] h);
      reply_type   r;
      int unsigned first;
      int unsigned idx;
      int unsigned id;
      bit          found;
      r.handle = '0;
      found    = 1'b0;
      if (act == ACTION_ALLOC) begin
         r.status = STATUS_FULL;
         first    = last_slot % ID_COUNT;
         idx      = (first + 1) % ID_COUNT;
         repeat (ID_COUNT) begin
            if (!found && !slot_taken[idx]) begin
               found           = 1'b1;
               slot_taken[idx] = 1'b1;
               last_slot       = idx;
               r.handle        = {lane, ID_W'(idx + 1)};
               r.status        = STATUS_ALLOCATED;
            end
            idx = (idx + 1) % ID_COUNT;
         end
      end else begin
         // Only bits 27..0 name the slot; the type nibble is don't-care.
         id = h[ID_W-1:0];
         if (id == 0 || id > ID_COUNT) begin
            r.status = STATUS_IGNORED;
         end else begin
            slot_taken[id-1] = 1'b0;
            r.status         = STATUS_FREED;
         end
      end
      return r;
   endfunction

   function automatic bit bitmap_full();
      foreach (slot_taken[s]) begin
         if (!slot_taken[s]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Find a slot in the wanted state, scanning from a random point; -1 if none.
   function automatic int pick_slot(input bit want_used);
      int base;
      int s;
      base = $urandom_range(ID_COUNT - 1);
      for (int k = 0; k < ID_COUNT; k++) begin
         s = (base + k) % ID_COUNT;
         if (slot_taken[s] == want_used) return s;
      end
      return -1;
   endfunction

   // Drive one request and hold it until the allocator takes it. Start is left
   // high afterwards so back-to-back requests need not toggle it again; the
   // next call either keeps it high or drops it for an idle gap.
   task automatic send_request(input logic act, input logic [TYPE_W-1:0] lane,
                               input logic [HANDLE_W-1:0] h);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_action         <= act;
      req_lane_type      <= lane;
      req_request_handle <= h;
      do @(posedge clock); while (busy);
      // Taken at this edge: book the response it owes.
      owed_replies.push_back(grant_or_release(act, lane, h));
      requests_sent++;
   endtask

   task automatic allocate(input logic [TYPE_W-1:0] lane);
      send_request(ACTION_ALLOC, lane, HANDLE_W'($urandom));
   endtask

   task automatic release_id(input logic [HANDLE_W-1:0] h);
      send_request(ACTION_FREE, TYPE_W'($urandom), h);
   endtask

   // Corner values of every field, the ignored-free cases, double free, and
   // the next-fit rule that a freed slot behind the cursor is not reused first.
   task automatic test_directed_edges();
      send_request(ACTION_ALLOC, 4'h0, '0);
      send_request(ACTION_ALLOC, 4'hF, '1);
      allocate(4'hA);
      release_id('0);
      release_id(32'hF000_0000);
      release_id(HANDLE_W'(ID_COUNT + 1));
      release_id(32'h0FFF_FFFF);
      release_id('1);
      // Top slot, never granted: freeing it is still a plain free.
      release_id(HANDLE_W'(ID_COUNT));
      send_request(ACTION_FREE, 4'hF, {4'hA, ID_W'(2)});
      release_id(HANDLE_W'(2));
      release_id(HANDLE_W'(1));
      allocate(4'h5);
      release_id(HANDLE_W'(5));
      allocate(4'h3);
   endtask

   // Fill every slot, hit the all-used answer, then punch holes and check the
   // wrap order, including the last granted slot being examined last.
   task automatic test_fill_and_wrap();
      int held;
      while (!bitmap_full()) allocate(TYPE_W'($urandom));
      allocate(TYPE_W'($urandom));
      allocate(TYPE_W'($urandom));
      release_id(HANDLE_W'(ID_COUNT + 7));
      held = last_slot;
      release_id({4'h7, ID_W'(held + 1)});
      allocate(4'h9);
      release_id(HANDLE_W'(1));
      release_id(HANDLE_W'(ID_COUNT));
      release_id(HANDLE_W'(33));
      release_id(HANDLE_W'(32));
      allocate(4'h1);
      allocate(4'h2);
      allocate(4'h4);
      allocate(4'h8);
      allocate(4'hC);
   endtask

   // Mostly well-formed traffic: allocate, or free a live handle with a random
   // type nibble; the rest is noise (bad ids, zero ids, frees of free slots).
   task automatic test_random_mix(input int count, input int alloc_pct);
      int roll;
      int s;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll >= 85) begin
            case ($urandom_range(3))
               0: release_id(HANDLE_W'($urandom));
               1: release_id({TYPE_W'($urandom), ID_W'(0)});
               2: release_id({TYPE_W'($urandom),
                              ID_W'($urandom_range(ID_COUNT + 1, 28'h0FFF_FFFF))});
               default: begin
                  s = pick_slot(1'b0);
                  if (s < 0) release_id(HANDLE_W'($urandom));
                  else release_id({TYPE_W'($urandom), ID_W'(s + 1)});
               end
            endcase
         end else if (roll < alloc_pct) begin
            allocate(TYPE_W'($urandom));
         end else begin
            s = pick_slot(1'b1);
            if (s < 0) allocate(TYPE_W'($urandom));
            else release_id({TYPE_W'($urandom), ID_W'(s + 1)});
         end
      end
   endtask

   // Compare each response with the oldest one owed; responses cannot be held
   // off, so sample rsp_* at every edge where rsp_valid is high.
   always @(posedge clock) begin : check_reply
      reply_type want;
      if (!reset && rsp_valid) begin
         status_tally[rsp_status]++;
         if (owed_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: handle=%h status=%0d", rsp_handle, rsp_status);
         end else begin
            want = owed_replies.pop_front();
            if (rsp_handle !== want.handle || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected handle=%h status=%0d, got handle=%h status=%0d",
                           want.handle, want.status, rsp_handle, rsp_status);
            end
         end
      end
   end

   initial begin : run_tests
      reset              = 1'b1;
      start              = 1'b0;
      req_action         = ACTION_ALLOC;
      req_lane_type      = '0;
      req_request_handle = '0;
      last_slot          = 0;
      idle_pct           = 26;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_fill_and_wrap();
      test_random_mix(200, 30);
      idle_pct = 51;
      test_random_mix(200, 45);
      idle_pct = 0;
      test_random_mix(200, 55);
      start <= 1'b0;

      // Drain: wait out every owed response, then a margin past the longest scan.
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (WORD_COUNT + 8) @(posedge clock);

      $display("Covered %0d requests: %0d grants, %0d frees, %0d all-used answers,",
               requests_sent, status_tally[STATUS_ALLOCATED], status_tally[STATUS_FREED],
               status_tally[STATUS_FULL]);
      $display("%0d ignored frees; %0d responses wrong or unexpected.",
               status_tally[STATUS_IGNORED], mismatches);
      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
